FILE: rtl/psme_pkg.sv
// shared constants and command codes for the pair swap move evaluator
`default_nettype none

package psme_pkg;

    localparam int MAX_PERSONS_DEF = 64;
    localparam int MAX_ROOMS_DEF   = 32;

    localparam int CMD_W    = 3;
    localparam int ROOM_W   = 5;
    localparam int PERSON_W = 6;
    localparam int COST_W   = 16;
    localparam int DELTA_W  = 19;
    localparam int TOTAL_W  = 32;
    localparam int PCNT_W   = 7;
    localparam int RCNT_W   = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [PCNT_W-1:0] PCNT_RST = 7'd64;
    localparam logic [RCNT_W-1:0] RCNT_RST = 6'd32;

    localparam logic REG_PERSON_COUNT = 1'b0;
    localparam logic REG_ROOM_COUNT   = 1'b1;

    localparam logic [CMD_W-1:0] CMD_WRITE_COST = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NAIVE_INIT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY_SWAP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_APPLY_SWAP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RECOMPUTE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_ROOM   = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/pair_swap_move_evaluator.sv
// top level: room assignment store, pairing cost memory and swap move sequencer
//
// usage: configuration registers person_count (byte address 0) and room_count
// (byte address 4) are to be written over the apb port only while the block is
// idle; the block itself does not enforce this. a command word is taken at a clock
// edge where start is high and busy is low; busy stays high while a multi-cycle
// command runs, and no new word is taken. every command gives one result word
// on the o_ ports, marked by o_valid for exactly one cycle; the receiver cannot
// hold it off.
// all commands share one 32-bit add/sub unit and one read port each on the
// cost memory and the room memory. the steps of each command:
//   write cost, set room, unused codes, out of range swaps: answered without busy
//   query swap: two room reads, four cost reads, accumulate
//   apply swap: query swap steps; unless rejected, two room writes, total update
//   naive init / recompute total: one room written / read per cycle
// reset clears the rooms to empty, the total to zero and the registers to
// their defaults at once; the cost memory holds no defined value until written
`default_nettype none

module pair_swap_move_evaluator #(
    parameter int MAX_PERSONS = psme_pkg::MAX_PERSONS_DEF,
    parameter int MAX_ROOMS   = psme_pkg::MAX_ROOMS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [psme_pkg::CMD_W-1:0]      i_cmd,
    input  logic [psme_pkg::ROOM_W-1:0]     i_room_a,
    input  logic                            i_slot_a_is_first,
    input  logic [psme_pkg::ROOM_W-1:0]     i_room_b,
    input  logic                            i_slot_b_is_first,
    input  logic [psme_pkg::PERSON_W-1:0]   i_person_x,
    input  logic [psme_pkg::PERSON_W-1:0]   i_person_y,
    input  logic signed [psme_pkg::COST_W-1:0] i_cost_value,
    output logic                            o_valid,
    output logic signed [psme_pkg::DELTA_W-1:0] o_swap_delta,
    output logic signed [psme_pkg::TOTAL_W-1:0] o_total_cost,
    output logic                            o_swap_applied,
    output logic                            o_status,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psme_pkg::ADDR_W-1:0]     paddr,
    input  logic [psme_pkg::DATA_W-1:0]     pwdata,
    output logic [psme_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import psme_pkg::*;

    localparam int PW     = $clog2(MAX_PERSONS);
    localparam int RW     = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int NPW    = ($clog2(MAX_PERSONS + 1) > PCNT_W) ?
                            $clog2(MAX_PERSONS + 1) : PCNT_W;
    localparam int NRW    = ($clog2(MAX_ROOMS + 1) > RCNT_W) ?
                            $clog2(MAX_ROOMS + 1) : RCNT_W;
    localparam int CW     = ((NRW + 1) > NPW) ? (NRW + 1) : NPW;
    localparam int CDEPTH = 1 << (2 * PW);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_SWAP = 2'd2;

    localparam logic [3:0] ST_RD_A   = 4'd0;
    localparam logic [3:0] ST_RD_B   = 4'd1;
    localparam logic [3:0] ST_LAT_B  = 4'd2;
    localparam logic [3:0] ST_C_A    = 4'd3;
    localparam logic [3:0] ST_C_B    = 4'd4;
    localparam logic [3:0] ST_C_NA   = 4'd5;
    localparam logic [3:0] ST_C_NB   = 4'd6;
    localparam logic [3:0] ST_WAIT   = 4'd7;
    localparam logic [3:0] ST_DECIDE = 4'd8;
    localparam logic [3:0] ST_TOT    = 4'd9;

    typedef struct packed {
        logic [PW-1:0] first;
        logic [PW-1:0] second;
    } t_room;

    // storage
    t_room       r_room_mem [MAX_ROOMS];
    logic [COST_W-1:0] r_cost_mem [CDEPTH];

    // control state
    logic [1:0]           r_state, n_state;
    logic [3:0]           r_step, n_step;
    logic [NRW-1:0]       r_cnt, n_cnt;
    logic                 r_init, n_init;
    logic [MAX_ROOMS-1:0] r_room_vld, n_room_vld;
    logic                 r_room_pend, n_room_pend;
    logic                 r_cost_pend, n_cost_pend;
    logic                 r_cost_neg, n_cost_neg;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [PCNT_W-1:0]    r_person_count;
    logic [RCNT_W-1:0]    r_room_count;
    logic                 r_valid, n_valid;

    // payload
    logic [TOTAL_W-1:0]   r_acc, n_acc;
    logic [CMD_W-1:0]     r_cmd, n_cmd;
    logic [ROOM_W-1:0]    r_ra, n_ra, r_rb, n_rb;
    logic                 r_sa, n_sa, r_sb, n_sb;
    t_room                r_a, n_a, r_b, n_b;
    t_room                r_rq;
    logic                 r_rq_vld;
    logic [COST_W-1:0]    r_cq;
    logic [DELTA_W-1:0]   r_o_delta, n_o_delta;
    logic [TOTAL_W-1:0]   r_o_total, n_o_total;
    logic                 r_o_applied, n_o_applied;
    logic                 r_o_status, n_o_status;

    // memory ports
    logic                 room_we;
    logic [RW-1:0]        room_wa, room_ra;
    t_room                room_wd;
    logic                 cost_we;
    logic [2*PW-1:0]      cost_wa, cost_ra;

    logic [NPW-1:0]       np;
    logic [NRW-1:0]       nr;
    logic                 accept;
    t_room                room_q;
    logic [PW-1:0]        pick_a, pick_b;
    t_room                na, nb;
    logic [CW-1:0]        p1, p2;
    t_room                init_room;
    logic                 use_tot;
    logic [TOTAL_W-1:0]   add_a, add_b, add_sum;
    logic                 add_sub;
    logic                 px_ok, py_ok, ra_ok, rb_ok;

    assign np = (NPW'(r_person_count) > NPW'(MAX_PERSONS)) ?
                NPW'(MAX_PERSONS) : NPW'(r_person_count);
    assign nr = (NRW'(r_room_count) > NRW'(MAX_ROOMS)) ?
                NRW'(MAX_ROOMS) : NRW'(r_room_count);

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;

    assign px_ok = NPW'(i_person_x) < np;
    assign py_ok = NPW'(i_person_y) < np;
    assign ra_ok = NRW'(i_room_a) < nr;
    assign rb_ok = NRW'(i_room_b) < nr;

    assign room_q = r_rq_vld ? r_rq : '0;

    // exchange of the two chosen slots
    assign pick_a    = r_sa ? r_a.first : r_a.second;
    assign pick_b    = r_sb ? r_b.first : r_b.second;
    assign na.first  = r_sa ? pick_b : r_a.first;
    assign na.second = r_sa ? r_a.second : pick_b;
    assign nb.first  = r_sb ? pick_a : r_b.first;
    assign nb.second = r_sb ? r_b.second : pick_a;

    // naive fill of room r_cnt
    assign p1 = (CW'(r_cnt) << 1) + CW'(1);
    assign p2 = (CW'(r_cnt) << 1) + CW'(2);
    assign init_room.first  = (p1 < CW'(np)) ? PW'(p1) : '0;
    assign init_room.second = (p2 < CW'(np)) ? PW'(p2) : '0;

    // shared add/sub unit
    assign use_tot = (r_state == S_SWAP) && (r_step == ST_TOT);
    assign add_a   = use_tot ? r_total : r_acc;
    assign add_b   = use_tot ? r_acc : {{(TOTAL_W-COST_W){r_cq[COST_W-1]}}, r_cq};
    assign add_sub = !use_tot && r_cost_neg;
    assign add_sum = add_a + (add_b ^ {TOTAL_W{add_sub}}) + TOTAL_W'(add_sub);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_init      = r_init;
        n_room_vld  = r_room_vld;
        n_room_pend = 1'b0;
        n_cost_pend = 1'b0;
        n_cost_neg  = 1'b0;
        n_total     = r_total;
        n_valid     = 1'b0;
        n_acc       = r_cost_pend ? add_sum : r_acc;
        n_cmd       = r_cmd;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_a         = r_a;
        n_b         = r_b;
        n_o_delta   = r_o_delta;
        n_o_total   = r_o_total;
        n_o_applied = r_o_applied;
        n_o_status  = r_o_status;
        room_we     = 1'b0;
        room_wa     = '0;
        room_wd     = '0;
        room_ra     = '0;
        cost_we     = 1'b0;
        cost_wa     = {PW'(i_person_x), PW'(i_person_y)};
        cost_ra     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_cmd;
                    n_ra  = i_room_a;
                    n_rb  = i_room_b;
                    n_sa  = i_slot_a_is_first;
                    n_sb  = i_slot_b_is_first;
                    n_acc = '0;
                    n_cnt = '0;
                    n_step = ST_RD_A;
                    n_o_delta   = '0;
                    n_o_total   = r_total;
                    n_o_applied = 1'b0;
                    n_o_status  = 1'b0;
                    case (i_cmd)
                        CMD_WRITE_COST: begin
                            cost_we    = px_ok && py_ok;
                            n_o_status = !(px_ok && py_ok);
                            n_valid    = 1'b1;
                        end
                        CMD_NAIVE_INIT: begin
                            n_room_vld = '0;
                            n_init     = 1'b1;
                            n_state    = S_WALK;
                        end
                        CMD_QUERY_SWAP, CMD_APPLY_SWAP: begin
                            if (ra_ok && rb_ok) begin
                                n_state = S_SWAP;
                            end else begin
                                n_o_status = 1'b1;
                                n_valid    = 1'b1;
                            end
                        end
                        CMD_RECOMPUTE: begin
                            n_init  = 1'b0;
                            n_state = S_WALK;
                        end
                        CMD_SET_ROOM: begin
                            if (ra_ok && px_ok && py_ok) begin
                                room_we = 1'b1;
                                room_wa = RW'(i_room_a);
                                room_wd = '{first: PW'(i_person_x), second: PW'(i_person_y)};
                                n_room_vld[RW'(i_room_a)] = 1'b1;
                            end else begin
                                n_o_status = 1'b1;
                            end
                            n_valid = 1'b1;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_cnt < nr) begin
                    if (r_init) begin
                        room_we     = 1'b1;
                        room_wa     = RW'(r_cnt);
                        room_wd     = init_room;
                        n_room_vld[RW'(r_cnt)] = 1'b1;
                        cost_ra     = {init_room.first, init_room.second};
                        n_cost_pend = 1'b1;
                    end else begin
                        room_ra     = RW'(r_cnt);
                        n_room_pend = 1'b1;
                    end
                    n_cnt = r_cnt + NRW'(1);
                end
                if (r_room_pend) begin
                    cost_ra     = {room_q.first, room_q.second};
                    n_cost_pend = 1'b1;
                end
                if ((r_cnt == nr) && !r_room_pend && !r_cost_pend) begin
                    n_total   = r_acc;
                    n_o_total = r_acc;
                    n_valid   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_SWAP: begin
                n_step = r_step + 4'd1;
                unique case (r_step)
                    ST_RD_A: begin
                        room_ra     = RW'(r_ra);
                        n_room_pend = 1'b1;
                    end
                    ST_RD_B: begin
                        room_ra     = RW'(r_rb);
                        n_room_pend = 1'b1;
                        n_a         = room_q;
                    end
                    ST_LAT_B: begin
                        n_b = room_q;
                    end
                    ST_C_A: begin
                        cost_ra     = {r_a.first, r_a.second};
                        n_cost_pend = 1'b1;
                        n_cost_neg  = 1'b1;
                    end
                    ST_C_B: begin
                        cost_ra     = {r_b.first, r_b.second};
                        n_cost_pend = 1'b1;
                        n_cost_neg  = 1'b1;
                    end
                    ST_C_NA: begin
                        cost_ra     = {na.first, na.second};
                        n_cost_pend = 1'b1;
                    end
                    ST_C_NB: begin
                        cost_ra     = {nb.first, nb.second};
                        n_cost_pend = 1'b1;
                    end
                    ST_WAIT: begin
                    end
                    ST_DECIDE: begin
                        if (r_cmd == CMD_QUERY_SWAP) begin
                            n_o_delta = DELTA_W'(r_acc);
                            n_valid   = 1'b1;
                            n_state   = S_IDLE;
                        end else if ((na.first == na.second) || (nb.first == nb.second)) begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            room_we = 1'b1;
                            room_wa = RW'(r_ra);
                            room_wd = na;
                            n_room_vld[RW'(r_ra)] = 1'b1;
                        end
                    end
                    ST_TOT: begin
                        room_we     = 1'b1;
                        room_wa     = RW'(r_rb);
                        room_wd     = nb;
                        n_room_vld[RW'(r_rb)] = 1'b1;
                        n_total     = add_sum;
                        n_o_total   = add_sum;
                        n_o_delta   = DELTA_W'(r_acc);
                        n_o_applied = 1'b1;
                        n_valid     = 1'b1;
                        n_state     = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (room_we) begin
            r_room_mem[room_wa] <= room_wd;
        end
        r_rq     <= r_room_mem[room_ra];
        r_rq_vld <= r_room_vld[room_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            r_cost_mem[cost_wa] <= i_cost_value;
        end
        r_cq <= r_cost_mem[cost_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= ST_RD_A;
            r_cnt          <= '0;
            r_init         <= 1'b0;
            r_room_vld     <= '0;
            r_room_pend    <= 1'b0;
            r_cost_pend    <= 1'b0;
            r_cost_neg     <= 1'b0;
            r_total        <= '0;
            r_valid        <= 1'b0;
            r_person_count <= PCNT_RST;
            r_room_count   <= RCNT_RST;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_init      <= n_init;
            r_room_vld  <= n_room_vld;
            r_room_pend <= n_room_pend;
            r_cost_pend <= n_cost_pend;
            r_cost_neg  <= n_cost_neg;
            r_total     <= n_total;
            r_valid     <= n_valid;
            if (psel && penable && pwrite) begin
                unique case (paddr[2])
                    REG_PERSON_COUNT: r_person_count <= pwdata[PCNT_W-1:0];
                    REG_ROOM_COUNT:   r_room_count   <= pwdata[RCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_cmd       <= n_cmd;
        r_ra        <= n_ra;
        r_rb        <= n_rb;
        r_sa        <= n_sa;
        r_sb        <= n_sb;
        r_a         <= n_a;
        r_b         <= n_b;
        r_o_delta   <= n_o_delta;
        r_o_total   <= n_o_total;
        r_o_applied <= n_o_applied;
        r_o_status  <= n_o_status;
    end

    always_comb begin
        unique case (paddr[2])
            REG_PERSON_COUNT: prdata = DATA_W'(r_person_count);
            REG_ROOM_COUNT:   prdata = DATA_W'(r_room_count);
            default:          prdata = '0;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_swap_delta   = r_o_delta;
    assign o_total_cost   = r_o_total;
    assign o_swap_applied = r_o_applied;
    assign o_status       = r_o_status;

endmodule

`default_nettype wire

FILE: rtl/psme_checker.sv
// port-level checks for the pair swap move evaluator, bound to the top level
`default_nettype none

module psme_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic [psme_pkg::CMD_W-1:0]          i_cmd,
    input wire logic                                o_valid,
    input wire logic signed [psme_pkg::DELTA_W-1:0] o_swap_delta,
    input wire logic                                o_swap_applied,
    input wire logic                                o_status
);
    import psme_pkg::*;

    // write cost and set room commands answer in the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == CMD_WRITE_COST || i_cmd == CMD_SET_ROOM)
        |=> o_valid && !busy)
        else $error("single-cycle command gave no result word");

    // an accepted word either starts work or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted word neither started nor answered");

    // a result word never appears while a command is running
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word shown while busy");

    // an out of range word carries no swap effect
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_swap_delta == '0 && !o_swap_applied)
        else $error("error word with nonzero delta or applied swap");

endmodule

bind pair_swap_move_evaluator psme_checker u_psme_checker (.*);

`default_nettype wire
